>>> design/cubic_resampler_gain_ramp_mixer_top_macros.svh
// Assertion helpers shared by the checking code of the resampler.
`ifndef CUBIC_RESAMPLER_GAIN_RAMP_MIXER_TOP_MACROS_SVH
`define CUBIC_RESAMPLER_GAIN_RAMP_MIXER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset
`define CRGM_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("crgm check failed");

// Next-cycle implication, sampled on clk, off during reset
`define CRGM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("crgm check failed");

`endif

>>> design/crgm_pkg.sv
`timescale 1ns / 1ps
package crgm_pkg;

    localparam int CRGM_FIFO_DEPTH = 1024;
    localparam int CRGM_PHASE_BITS = 24;

    localparam int STEP_W  = 27;
    localparam int GSTEP_W = 18;
    localparam int GAIN_W  = 17;
    localparam int LEVEL_W = 18;
    localparam int SMP_W   = 16;
    localparam int MIX_W   = 24;
    localparam int CFG_AW  = 3;
    localparam int CFG_DW  = 27;

    // Register indexes on the configuration port
    localparam logic [CFG_AW-1:0] REG_STEP_RATIO   = 3'd0;
    localparam logic [CFG_AW-1:0] REG_GAIN_STEP    = 3'd1;
    localparam logic [CFG_AW-1:0] REG_TARGET_LEFT  = 3'd2;
    localparam logic [CFG_AW-1:0] REG_TARGET_RIGHT = 3'd3;
    localparam logic [CFG_AW-1:0] REG_STEREO       = 3'd4;
    localparam logic [CFG_AW-1:0] REG_FADE_OUT     = 3'd5;

    // Result status codes
    localparam logic [1:0] ST_PUSHED  = 2'd0;
    localparam logic [1:0] ST_DROPPED = 2'd1;
    localparam logic [1:0] ST_MIXED   = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;

    // Input opcodes
    localparam logic OP_PUSH    = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    typedef struct packed {
        logic                     opcode;
        logic signed [SMP_W-1:0]  sample_left;
        logic signed [SMP_W-1:0]  sample_right;
        logic signed [MIX_W-1:0]  mix_in_left;
        logic signed [MIX_W-1:0]  mix_in_right;
    } crgm_item_t;

    typedef struct packed {
        logic [STEP_W-1:0]  step_ratio;
        logic [GSTEP_W-1:0] gain_step;
        logic [GAIN_W-1:0]  target_left_gain;
        logic [GAIN_W-1:0]  target_right_gain;
        logic               stereo_source;
        logic               fade_out;
    } crgm_cfg_t;

endpackage

>>> design/crgm_front.sv
`timescale 1ns / 1ps
module crgm_front
    import crgm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  crgm_item_t  in_item,
    output logic        q_valid,
    input  logic        q_ready,
    output crgm_item_t  q_item
);

    crgm_item_t  slot_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic        push_w;
    logic        pop_w;

    assign in_ready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = slot_reg[rd_ptr_reg];
    assign push_w   = in_valid && in_ready;
    assign pop_w    = q_valid && q_ready;

    // Hold words in a two-entry queue
    always_ff @(posedge clk)
    begin
        if (push_w)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push_w)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop_w)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push_w && !pop_w)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop_w && !push_w)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

>>> design/crgm_core.sv
`timescale 1ns / 1ps
module crgm_core
    import crgm_pkg::*;
#(
    parameter int FIFO_DEPTH = CRGM_FIFO_DEPTH,
    parameter int PHASE_BITS = CRGM_PHASE_BITS
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  crgm_cfg_t                           cfg,
    input  logic                                q_valid,
    output logic                                q_ready,
    input  crgm_item_t                          q_item,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [1:0]                          out_status,
    output logic [2*MIX_W-1:0]                  out_data,
    output logic [$clog2(FIFO_DEPTH+1)-1:0]     fill_level
);

    localparam int AW    = $clog2(FIFO_DEPTH);
    localparam int CW    = $clog2(FIFO_DEPTH + 1);
    localparam int XW    = AW + 2;
    localparam int SUM_W = ((PHASE_BITS > STEP_W) ? PHASE_BITS : STEP_W) + 1;
    localparam int ADV_W = SUM_W - PHASE_BITS;
    localparam int CMP_W = (ADV_W > CW) ? ADV_W : CW;
    localparam int ACC_W = 40;
    localparam int MB_W  = 19;
    localparam int PR_W  = ACC_W + MB_W;
    localparam int WS_W  = 64;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_READ = 5'b00010,
        S_COEF = 5'b00100,
        S_MATH = 5'b01000,
        S_FIN  = 5'b10000
    } crgm_state_t;

    crgm_state_t                 state_reg;
    logic [31:0]                 mem [FIFO_DEPTH];
    logic [31:0]                 rd_data_reg;
    logic [AW-1:0]               addr_reg [4];
    logic [31:0]                 frame_reg [4];
    logic [AW-1:0]               wp_reg;
    logic [AW-1:0]               rp_reg;
    logic [CW-1:0]               fill_reg;
    logic                        have_prev_reg;
    logic [PHASE_BITS-1:0]       phase_reg;
    logic [LEVEL_W-1:0]          left_level_reg;
    logic [LEVEL_W-1:0]          right_level_reg;
    logic                        started_reg;
    logic [15:0]                 tq_reg;
    logic                        stereo_reg;
    logic signed [MIX_W-1:0]     mix_l_reg;
    logic signed [MIX_W-1:0]     mix_r_reg;
    logic [2:0]                  rcnt_reg;
    logic [3:0]                  k_reg;
    logic                        ch_reg;
    logic signed [16:0]          c1_reg;
    logic signed [19:0]          c2_reg;
    logic signed [19:0]          c3_reg;
    logic signed [SMP_W-1:0]     p1_reg;
    logic signed [ACC_W-1:0]     acc_reg;
    logic signed [PR_W-1:0]      prod_reg;
    logic signed [PR_W-1:0]      plo_reg;
    logic signed [MIX_W-1:0]     res_l_reg;
    logic                        out_valid_reg;
    logic [1:0]                  out_status_reg;
    logic [2*MIX_W-1:0]          out_data_reg;

    logic                        slot_free;
    logic                        dispatch;
    logic                        mem_we;
    logic [AW-1:0]               rd_addr;
    logic [GAIN_W-1:0]           tgt_l;
    logic [GAIN_W-1:0]           tgt_r;
    logic                        full;
    logic [XW-1:0]               rp_x;
    logic [XW-1:0]               nx_x;
    logic [XW-1:0]               af_x;
    logic [AW-1:0]               before_a;
    logic [AW-1:0]               next_a;
    logic [AW-1:0]               after_a;
    logic [SUM_W-1:0]            sum;
    logic [CMP_W-1:0]            adv;
    logic [CMP_W-1:0]            fill_c;
    logic [CMP_W-1:0]            advc;
    logic [XW-1:0]               rp_adv;
    logic [PHASE_BITS+15:0]      tq_wide;
    logic signed [SMP_W-1:0]     p0;
    logic signed [SMP_W-1:0]     p1;
    logic signed [SMP_W-1:0]     p2;
    logic signed [SMP_W-1:0]     p3;
    logic signed [19:0]          e0;
    logic signed [19:0]          e1;
    logic signed [19:0]          e2;
    logic signed [19:0]          e3;
    logic [LEVEL_W-1:0]          level_cur;
    logic signed [ACC_W-1:0]     s_val;
    logic signed [ACC_W-1:0]     mul_a;
    logic signed [MB_W-1:0]      mul_b;
    logic signed [WS_W-1:0]      wsum;
    logic signed [WS_W-1:0]      wadd;
    logic signed [ACC_W-1:0]     tot;
    logic signed [MIX_W-1:0]     sat;
    logic [LEVEL_W-1:0]          left_next;
    logic [LEVEL_W-1:0]          right_next;
    logic signed [ACC_W-1:0]     shr_prod;

    assign slot_free  = !out_valid_reg || out_ready;
    assign dispatch   = (state_reg == S_IDLE) && q_valid && slot_free;
    assign q_ready    = dispatch;
    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_data   = out_data_reg;
    assign fill_level = fill_reg;

    assign tgt_l = cfg.fade_out ? '0 : cfg.target_left_gain;
    assign tgt_r = cfg.fade_out ? '0 : cfg.target_right_gain;
    assign full  = ({1'b0, fill_reg} + (CW+1)'(have_prev_reg)) >= (CW+1)'(FIFO_DEPTH);
    assign mem_we = dispatch && (q_item.opcode == OP_PUSH) && !full;

    // Neighbor addresses, wrapped at the store depth
    always_comb
    begin
        rp_x = XW'(rp_reg);
        nx_x = rp_x + XW'(1);
        if (nx_x >= XW'(FIFO_DEPTH))
        begin
            nx_x = nx_x - XW'(FIFO_DEPTH);
        end
        af_x = rp_x + XW'(2);
        if (af_x >= XW'(FIFO_DEPTH))
        begin
            af_x = af_x - XW'(FIFO_DEPTH);
        end
        if (!have_prev_reg)
        begin
            before_a = rp_reg;
        end
        else if (rp_reg == '0)
        begin
            before_a = AW'(FIFO_DEPTH - 1);
        end
        else
        begin
            before_a = rp_reg - AW'(1);
        end
        next_a  = (fill_reg > CW'(1)) ? nx_x[AW-1:0] : rp_reg;
        after_a = (fill_reg > CW'(2)) ? af_x[AW-1:0] : next_a;
    end

    // Phase advance, clamped to stored frames
    always_comb
    begin
        sum     = SUM_W'(phase_reg) + SUM_W'(cfg.step_ratio);
        adv     = CMP_W'(sum[SUM_W-1:PHASE_BITS]);
        fill_c  = CMP_W'(fill_reg);
        advc    = (adv > fill_c) ? fill_c : adv;
        rp_adv  = XW'(rp_reg) + XW'(advc);
        if (rp_adv >= XW'(FIFO_DEPTH))
        begin
            rp_adv = rp_adv - XW'(FIFO_DEPTH);
        end
        tq_wide = {phase_reg, 16'd0};
    end

    // Pick the channel half of each stored frame
    always_comb
    begin
        if (ch_reg && stereo_reg)
        begin
            p0 = frame_reg[0][31:16];
            p1 = frame_reg[1][31:16];
            p2 = frame_reg[2][31:16];
            p3 = frame_reg[3][31:16];
        end
        else
        begin
            p0 = frame_reg[0][15:0];
            p1 = frame_reg[1][15:0];
            p2 = frame_reg[2][15:0];
            p3 = frame_reg[3][15:0];
        end
        e0 = 20'(p0);
        e1 = 20'(p1);
        e2 = 20'(p2);
        e3 = 20'(p3);
    end

    // Slide levels one step toward their targets
    always_comb
    begin
        if (left_level_reg < LEVEL_W'(tgt_l))
        begin
            left_next = ((LEVEL_W+1)'(left_level_reg) + (LEVEL_W+1)'(cfg.gain_step)
                         < (LEVEL_W+1)'(tgt_l))
                        ? left_level_reg + cfg.gain_step : LEVEL_W'(tgt_l);
        end
        else
        begin
            left_next = ($signed({2'b00, left_level_reg}) - $signed({2'b00, cfg.gain_step})
                         > $signed({3'b000, tgt_l}))
                        ? left_level_reg - cfg.gain_step : LEVEL_W'(tgt_l);
        end
        if (right_level_reg < LEVEL_W'(tgt_r))
        begin
            right_next = ((LEVEL_W+1)'(right_level_reg) + (LEVEL_W+1)'(cfg.gain_step)
                          < (LEVEL_W+1)'(tgt_r))
                         ? right_level_reg + cfg.gain_step : LEVEL_W'(tgt_r);
        end
        else
        begin
            right_next = ($signed({2'b00, right_level_reg}) - $signed({2'b00, cfg.gain_step})
                          > $signed({3'b000, tgt_r}))
                         ? right_level_reg - cfg.gain_step : LEVEL_W'(tgt_r);
        end
    end

    // Shared multiplier operand select
    always_comb
    begin
        level_cur = ch_reg ? right_level_reg : left_level_reg;
        s_val     = acc_reg >>> 1;
        shr_prod  = ACC_W'(prod_reg >>> 16);
        case (k_reg)
            4'd0:
            begin
                mul_a = ACC_W'(c3_reg);
                mul_b = MB_W'($signed({1'b0, tq_reg}));
            end
            4'd2, 4'd4:
            begin
                mul_a = acc_reg;
                mul_b = MB_W'($signed({1'b0, tq_reg}));
            end
            4'd6:
            begin
                mul_a = s_val;
                mul_b = MB_W'($signed({1'b0, level_cur[8:0]}));
            end
            4'd8:
            begin
                mul_a = s_val;
                mul_b = MB_W'($signed({1'b0, level_cur[17:9]}));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Weight, round half up and saturate
    always_comb
    begin
        wsum = (WS_W'(prod_reg) <<< 9) + WS_W'(plo_reg);
        wadd = (wsum + WS_W'(64'sd33554432)) >>> 26;
        tot  = ACC_W'(ch_reg ? mix_r_reg : mix_l_reg) + ACC_W'(wadd);
        if (tot > ACC_W'(40'sd8388607))
        begin
            sat = 24'sh7FFFFF;
        end
        else if (tot < -ACC_W'(40'sd8388608))
        begin
            sat = 24'sh800000;
        end
        else
        begin
            sat = tot[MIX_W-1:0];
        end
    end

    assign rd_addr = addr_reg[rcnt_reg[1:0]];

    // Frame store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wp_reg] <= {q_item.sample_right, q_item.sample_left};
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (dispatch)
        begin
            addr_reg[0] <= before_a;
            addr_reg[1] <= rp_reg;
            addr_reg[2] <= next_a;
            addr_reg[3] <= after_a;
            tq_reg      <= tq_wide[PHASE_BITS+15:PHASE_BITS];
            stereo_reg  <= cfg.stereo_source;
            mix_l_reg   <= q_item.mix_in_left;
            mix_r_reg   <= q_item.mix_in_right;
        end
        if (state_reg == S_READ && rcnt_reg != 3'd0)
        begin
            frame_reg[rcnt_reg[1:0] - 2'd1] <= rd_data_reg;
        end
        if (state_reg == S_COEF)
        begin
            c1_reg <= 17'(e2 - e0);
            c2_reg <= (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
            c3_reg <= e3 - e0 + ((e1 - e2) <<< 1) + (e1 - e2);
            p1_reg <= p1;
        end
        if (state_reg == S_MATH)
        begin
            prod_reg <= PR_W'(mul_a) * PR_W'(mul_b);
            case (k_reg)
                4'd1:
                begin
                    acc_reg <= ACC_W'(prod_reg) + (ACC_W'(c2_reg) <<< 16);
                end
                4'd3:
                begin
                    acc_reg <= shr_prod + (ACC_W'(c1_reg) <<< 16);
                end
                4'd5:
                begin
                    acc_reg <= shr_prod + (ACC_W'(p1_reg) <<< 17);
                end
                4'd7:
                begin
                    plo_reg <= prod_reg;
                end
                4'd9:
                begin
                    if (!ch_reg)
                    begin
                        res_l_reg <= sat;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Sequencer, FIFO pointers and level state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            wp_reg          <= '0;
            rp_reg          <= '0;
            fill_reg        <= '0;
            have_prev_reg   <= 1'b0;
            phase_reg       <= '0;
            left_level_reg  <= '0;
            right_level_reg <= '0;
            started_reg     <= 1'b0;
            rcnt_reg        <= '0;
            k_reg           <= '0;
            ch_reg          <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_status_reg  <= ST_PUSHED;
            out_data_reg    <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (dispatch)
                    begin
                        if (q_item.opcode == OP_PUSH)
                        begin
                            out_valid_reg <= 1'b1;
                            out_data_reg  <= '0;
                            if (full)
                            begin
                                out_status_reg <= ST_DROPPED;
                            end
                            else
                            begin
                                out_status_reg <= ST_PUSHED;
                                wp_reg   <= (wp_reg == AW'(FIFO_DEPTH - 1))
                                            ? '0 : wp_reg + AW'(1);
                                fill_reg <= fill_reg + CW'(1);
                            end
                        end
                        else
                        begin
                            if (!started_reg)
                            begin
                                left_level_reg  <= LEVEL_W'(tgt_l);
                                right_level_reg <= LEVEL_W'(tgt_r);
                                started_reg     <= 1'b1;
                            end
                            if (fill_reg == '0)
                            begin
                                out_valid_reg  <= 1'b1;
                                out_status_reg <= ST_EMPTY;
                                out_data_reg   <= {q_item.mix_in_right, q_item.mix_in_left};
                            end
                            else
                            begin
                                phase_reg <= sum[PHASE_BITS-1:0];
                                if (advc != '0)
                                begin
                                    rp_reg        <= rp_adv[AW-1:0];
                                    fill_reg      <= fill_reg - CW'(advc);
                                    have_prev_reg <= 1'b1;
                                end
                                rcnt_reg  <= '0;
                                ch_reg    <= 1'b0;
                                state_reg <= S_READ;
                            end
                        end
                    end
                end
                S_READ:
                begin
                    rcnt_reg <= rcnt_reg + 3'd1;
                    if (rcnt_reg == 3'd4)
                    begin
                        state_reg <= S_COEF;
                    end
                end
                S_COEF:
                begin
                    if (!ch_reg)
                    begin
                        left_level_reg  <= left_next;
                        right_level_reg <= right_next;
                    end
                    k_reg     <= '0;
                    state_reg <= S_MATH;
                end
                S_MATH:
                begin
                    k_reg <= k_reg + 4'd1;
                    if (k_reg == 4'd9)
                    begin
                        if (!ch_reg)
                        begin
                            ch_reg    <= 1'b1;
                            state_reg <= S_COEF;
                        end
                        else
                        begin
                            out_data_reg <= {sat, res_l_reg};
                            state_reg    <= S_FIN;
                        end
                    end
                end
                S_FIN:
                begin
                    if (slot_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= ST_MIXED;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> design/cubic_resampler_gain_ramp_mixer_top.sv
`timescale 1ns / 1ps
// Cubic stereo resampler with gain ramp and saturating mix.
// Input stream (s_axis_*): tuser is the opcode (push a source frame or request
// one mixed output frame); tdata carries the source samples and the mix words.
// Output stream (m_axis_*): tuser is the status, tdata the two mixed samples.
// Configuration words arrive on cfg_valid/cfg_ready with a register index in
// cfg_addr; cfg_ready is always high. Write only while the block is idle.
// A two-entry queue sits in front of a sequencer that owns the frame store.
// A push or an empty request is answered from the output register after it
// leaves the queue; pushes stream at one per cycle while the receiver takes all
// words. A mixing request makes four frame reads on the single read port, then
// per channel a coefficient step and ten steps of the one shared 40x19 multiplier.
// When the receiver stalls, the finished word holds in the output register,
// the sequencer waits for it to drain, and the queue keeps taking words until
// both entries are filled. Reset empties the queue and the frame FIFO, zeroes
// the phase and levels, and loads register defaults; no clearing pass runs.
`include "cubic_resampler_gain_ramp_mixer_top_macros.svh"
module cubic_resampler_gain_ramp_mixer_top
    import crgm_pkg::*;
#(
    parameter int FIFO_DEPTH = CRGM_FIFO_DEPTH,
    parameter int PHASE_BITS = CRGM_PHASE_BITS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // sample_left, sample_right, mix_in_left, mix_in_right
    input  logic [79:0]         s_axis_tdata,
    // opcode
    input  logic                s_axis_tuser,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // mix_out_left, mix_out_right
    output logic [47:0]         m_axis_tdata,
    // status
    output logic [1:0]          m_axis_tuser,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CFG_AW-1:0]   cfg_addr,
    input  logic [CFG_DW-1:0]   cfg_data
);

    localparam int CW = $clog2(FIFO_DEPTH + 1);

    crgm_cfg_t        cfg_reg;
    crgm_item_t       in_item;
    crgm_item_t       q_item;
    logic             q_valid;
    logic             q_ready;
    logic [CW-1:0]    fill_level;
    logic             push_result;

    assign cfg_ready = 1'b1;

    assign in_item.opcode       = s_axis_tuser;
    assign in_item.sample_left  = s_axis_tdata[15:0];
    assign in_item.sample_right = s_axis_tdata[31:16];
    assign in_item.mix_in_left  = s_axis_tdata[55:32];
    assign in_item.mix_in_right = s_axis_tdata[79:56];

    assign push_result = m_axis_tvalid
                         && (m_axis_tuser == ST_PUSHED || m_axis_tuser == ST_DROPPED);

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_ratio        <= STEP_W'(16777216);
            cfg_reg.gain_step         <= GSTEP_W'(136);
            cfg_reg.target_left_gain  <= GAIN_W'(65536);
            cfg_reg.target_right_gain <= GAIN_W'(65536);
            cfg_reg.stereo_source     <= 1'b1;
            cfg_reg.fade_out          <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_addr)
                REG_STEP_RATIO:   cfg_reg.step_ratio        <= cfg_data[STEP_W-1:0];
                REG_GAIN_STEP:    cfg_reg.gain_step         <= cfg_data[GSTEP_W-1:0];
                REG_TARGET_LEFT:  cfg_reg.target_left_gain  <= cfg_data[GAIN_W-1:0];
                REG_TARGET_RIGHT: cfg_reg.target_right_gain <= cfg_data[GAIN_W-1:0];
                REG_STEREO:       cfg_reg.stereo_source     <= cfg_data[0];
                REG_FADE_OUT:     cfg_reg.fade_out          <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    crgm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    crgm_core #(
        .FIFO_DEPTH (FIFO_DEPTH),
        .PHASE_BITS (PHASE_BITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_item     (q_item),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_status (m_axis_tuser),
        .out_data   (m_axis_tdata),
        .fill_level (fill_level)
    );

    `CRGM_ASSERT_IMPL(a_fill_bound, 1'b1, fill_level <= (CW+1)'(FIFO_DEPTH))
    `CRGM_ASSERT_NEXT(a_fill_step, 1'b1, {1'b0, fill_level} <= {1'b0, $past(fill_level)} + 1'b1)
    `CRGM_ASSERT_IMPL(a_push_zero, push_result, m_axis_tdata == '0)

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
module tb;
    import crgm_pkg::*;

    typedef struct {
        logic [1:0]  status;
        logic [23:0] mix_left;
        logic [23:0] mix_right;
    } mix_word_t;

    // Scoreboard: mirrors the resampler state and holds the expected mix words
    class mix_scoreboard;
        logic [31:0] frames [CRGM_FIFO_DEPTH];
        int unsigned wr_ptr, rd_ptr, avail;
        bit          have_prev, levels_on;
        longint      phase_acc, lvl_left, lvl_right;
        longint      step_ratio, gain_step, tgt_left, tgt_right;
        bit          stereo, fade;
        mix_word_t   pending_q[$];
        int          errors;

        function new();
            wr_ptr = 0; rd_ptr = 0; avail = 0; have_prev = 0; levels_on = 0;
            phase_acc = 0; lvl_left = 0; lvl_right = 0;
            step_ratio = 16777216; gain_step = 136; tgt_left = 65536;
            tgt_right = 65536; stereo = 1; fade = 0; errors = 0;
        endfunction

        function void set_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
            case (idx)
                REG_STEP_RATIO:   step_ratio = val[STEP_W-1:0];
                REG_GAIN_STEP:    gain_step = val[GSTEP_W-1:0];
                REG_TARGET_LEFT:  tgt_left = val[GAIN_W-1:0];
                REG_TARGET_RIGHT: tgt_right = val[GAIN_W-1:0];
                REG_STEREO:       stereo = val[0];
                REG_FADE_OUT:     fade = val[0];
                default: ;
            endcase
        endfunction

        function longint sample_at(int unsigned idx, bit hi);
            logic [31:0] w;
            w = frames[idx % CRGM_FIFO_DEPTH];
            return hi ? longint'($signed(w[31:16])) : longint'($signed(w[15:0]));
        endfunction

        // Horner form of the doubled Catmull-Rom cubic, each step floored
        function longint catmull(longint p0, longint p1, longint p2, longint p3,
                                 longint tq);
            longint c1, c2, c3, acc;
            c1 = p2 - p0;
            c2 = 2 * p0 - 5 * p1 + 4 * p2 - p3;
            c3 = p3 - p0 + 3 * (p1 - p2);
            acc = c3 * 65536;
            acc = ((acc * tq) >>> 16) + c2 * 65536;
            acc = ((acc * tq) >>> 16) + c1 * 65536;
            acc = ((acc * tq) >>> 16) + 2 * p1 * 65536;
            return acc >>> 1;
        endfunction

        function longint slew(longint lvl, longint tgt);
            if (lvl < tgt)
                return (lvl + gain_step < tgt) ? lvl + gain_step : tgt;
            return (lvl - gain_step > tgt) ? lvl - gain_step : tgt;
        endfunction

        function logic [23:0] sat_add(logic [23:0] mix, longint smp, longint lvl);
            longint s;
            s = longint'($signed(mix)) + ((smp * lvl + (64'sd1 <<< 25)) >>> 26);
            if (s > 8388607) s = 8388607;
            if (s < -8388608) s = -8388608;
            return s[23:0];
        endfunction

        // Note an accepted input word and queue the word it must produce
        function void note(crgm_item_t it);
            mix_word_t   e;
            longint      tl, tr, tq, sl, sr, sum, adv;
            int unsigned bef, nxt, aft;
            e.mix_left = '0;
            e.mix_right = '0;
            if (it.opcode == OP_PUSH) begin
                if (avail + have_prev >= CRGM_FIFO_DEPTH)
                    e.status = ST_DROPPED;
                else begin
                    frames[wr_ptr] = {it.sample_right, it.sample_left};
                    wr_ptr = (wr_ptr + 1) % CRGM_FIFO_DEPTH;
                    avail++;
                    e.status = ST_PUSHED;
                end
            end else begin
                tl = fade ? 0 : tgt_left;
                tr = fade ? 0 : tgt_right;
                if (!levels_on) begin
                    lvl_left = tl; lvl_right = tr; levels_on = 1;
                end
                if (avail == 0) begin
                    e.status = ST_EMPTY;
                    e.mix_left = it.mix_in_left;
                    e.mix_right = it.mix_in_right;
                end else begin
                    bef = have_prev ? rd_ptr + CRGM_FIFO_DEPTH - 1 : rd_ptr;
                    nxt = avail > 1 ? rd_ptr + 1 : rd_ptr;
                    aft = avail > 2 ? rd_ptr + 2 : nxt;
                    tq = (phase_acc << 16) >> CRGM_PHASE_BITS;
                    sl = catmull(sample_at(bef, 0), sample_at(rd_ptr, 0),
                                 sample_at(nxt, 0), sample_at(aft, 0), tq);
                    sr = stereo ? catmull(sample_at(bef, 1), sample_at(rd_ptr, 1),
                                          sample_at(nxt, 1), sample_at(aft, 1), tq) : sl;
                    lvl_left = slew(lvl_left, tl);
                    lvl_right = slew(lvl_right, tr);
                    e.status = ST_MIXED;
                    e.mix_left = sat_add(it.mix_in_left, sl, lvl_left);
                    e.mix_right = sat_add(it.mix_in_right, sr, lvl_right);
                    sum = phase_acc + step_ratio;
                    adv = sum >> CRGM_PHASE_BITS;
                    phase_acc = sum & ((64'sd1 <<< CRGM_PHASE_BITS) - 1);
                    if (adv > avail) adv = avail;
                    if (adv > 0) begin
                        rd_ptr = (rd_ptr + adv) % CRGM_FIFO_DEPTH;
                        avail -= adv;
                        have_prev = 1;
                    end
                end
            end
            pending_q.push_back(e);
        endfunction

        // Compare one output word against the oldest expectation
        function void check(logic [1:0] st, logic [23:0] ml, logic [23:0] mr);
            mix_word_t e;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected word status=%0d left=%h right=%h",
                         $time, st, ml, mr);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            if (st !== e.status) begin
                $display("%0t: status expected %0d actual %0d", $time, e.status, st);
                errors++;
            end
            if (ml !== e.mix_left) begin
                $display("%0t: mix_out_left expected %h actual %h", $time, e.mix_left, ml);
                errors++;
            end
            if (mr !== e.mix_right) begin
                $display("%0t: mix_out_right expected %h actual %h",
                         $time, e.mix_right, mr);
                errors++;
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [79:0]       s_axis_tdata;
    logic              s_axis_tuser;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [47:0]       m_axis_tdata;
    logic [1:0]        m_axis_tuser;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [CFG_AW-1:0] cfg_addr;
    logic [CFG_DW-1:0] cfg_data;

    mix_scoreboard mix_sb;
    int            send_idle;
    int            recv_idle;
    int            words_seen;
    int            hold_left;
    bit            held;
    longint        cycles;

    cubic_resampler_gain_ramp_mixer_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 3000000)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Check every word leaving the block
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            mix_sb.check(m_axis_tuser, m_axis_tdata[23:0], m_axis_tdata[47:24]);
            words_seen <= words_seen + 1;
        end
    end

    // Receiver: random stalls, plus one long hold-off to back the block up
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (!held && words_seen >= 60)
        begin
            m_axis_tready <= 1'b0;
            held <= 1'b1;
            hold_left <= 400;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end

    // Write one register; valid stays high for a following write
    task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        mix_sb.set_reg(idx, val);
    endtask

    task automatic write_all(logic [26:0] step, logic [17:0] gstep, logic [16:0] tl,
                             logic [16:0] tr, logic st, logic fd);
        write_reg(REG_STEP_RATIO, step);
        write_reg(REG_GAIN_STEP, CFG_DW'(gstep));
        write_reg(REG_TARGET_LEFT, CFG_DW'(tl));
        write_reg(REG_TARGET_RIGHT, CFG_DW'(tr));
        write_reg(REG_STEREO, CFG_DW'(st));
        write_reg(REG_FADE_OUT, CFG_DW'(fd));
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Offer one input word and hold it until taken
    task automatic send_word(logic op, logic [15:0] sl, logic [15:0] sr,
                             logic [23:0] ml, logic [23:0] mr);
        crgm_item_t it;
        while ($urandom_range(99) < send_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {mr, ml, sr, sl};
        do @(posedge clk); while (!s_axis_tready);
        it.opcode = op;
        it.sample_left = sl;
        it.sample_right = sr;
        it.mix_in_left = ml;
        it.mix_in_right = mr;
        mix_sb.note(it);
    endtask

    function automatic logic [23:0] pick_mix();
        case ($urandom_range(7))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'h000000;
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic send_random(int push_pct);
        logic op;
        op = ($urandom_range(99) < push_pct) ? OP_PUSH : OP_REQUEST;
        send_word(op, 16'($urandom), 16'($urandom), pick_mix(), pick_mix());
    endtask

    // Drop valid and hold until every expected word is back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (mix_sb.pending_q.size() != 0) @(posedge clk);
    endtask

    initial
    begin
        mix_sb = new();
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        cfg_valid = 1'b0;
        cfg_addr = '0;
        cfg_data = '0;
        send_idle = 14;
        recv_idle = 46;
        words_seen = 0;
        hold_left = 0;
        held = 1'b0;
        cycles = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty requests, sample extremes, saturating mixes
        write_all(27'd16777216, 18'd136, 17'd65536, 17'd65536, 1'b1, 1'b0);
        send_word(OP_REQUEST, 16'h0, 16'h0, 24'h7FFFFF, 24'h800000);
        send_word(OP_REQUEST, 16'h0, 16'h0, 24'h123456, 24'hABCDEF);
        send_word(OP_PUSH, 16'h7FFF, 16'h8000, 24'h0, 24'h0);
        send_word(OP_REQUEST, 16'h0, 16'h0, 24'h7FFFFF, 24'h800000);
        send_word(OP_PUSH, 16'h8000, 16'h7FFF, 24'h0, 24'h0);
        send_word(OP_PUSH, 16'h7FFF, 16'h7FFF, 24'h0, 24'h0);
        send_word(OP_PUSH, 16'h8000, 16'h8000, 24'h0, 24'h0);
        send_word(OP_PUSH, 16'h0000, 16'hFFFF, 24'h0, 24'h0);
        send_word(OP_REQUEST, 16'h0, 16'h0, 24'h7FFFFF, 24'h7FFFFF);
        send_word(OP_REQUEST, 16'h0, 16'h0, 24'h800000, 24'h800000);
        send_word(OP_REQUEST, 16'h0, 16'h0, 24'h000000, 24'hFFFFFF);
        send_word(OP_REQUEST, 16'h0, 16'h0, 24'h400000, 24'hC00000);
        send_word(OP_REQUEST, 16'h0, 16'h0, 24'h0, 24'h0);
        send_word(OP_REQUEST, 16'h0, 16'h0, 24'h0, 24'h0);
        drain();

        // Random phases over several register settings
        for (int ph = 0; ph < 5; ph++)
        begin
            if (ph == 2) begin send_idle = 46; recv_idle = 14; end
            if (ph == 4) begin send_idle = 0; recv_idle = 0; end
            case (ph)
                0: write_all(27'd1, 18'd0, 17'd92682, 17'd0, 1'b0, 1'b0);
                1: write_all(27'd67108864, 18'd131072, 17'd0, 17'd92682, 1'b1, 1'b0);
                2: write_all(27'($urandom_range(33554432, 1)), 18'd300, 17'd92682,
                             17'd92682, 1'b1, 1'b1);
                3: write_all(27'($urandom_range(25000000, 8000000)),
                             18'($urandom_range(4000)),
                             17'($urandom_range(92682)), 17'($urandom_range(92682)),
                             1'b0, 1'b0);
                default: write_all(27'($urandom_range(67108864, 1)),
                                   18'($urandom_range(131072)),
                                   17'($urandom_range(92682)), 17'($urandom_range(92682)),
                                   1'($urandom_range(1)), 1'($urandom_range(1)));
            endcase
            for (int n = 0; n < 100; n++)
                send_random(ph == 1 ? 65 : 50);
            drain();
        end

        // Fill the frame FIFO deep, then drain it fast
        write_all(27'd1, 18'd136, 17'd65536, 17'd65536, 1'b1, 1'b0);
        for (int n = 0; n < 100; n++)
            send_random(100);
        send_random(0);
        drain();
        write_all(27'd67108864, 18'd2000, 17'd40000, 17'd80000, 1'b1, 1'b0);
        for (int n = 0; n < 80; n++)
            send_random(2);
        drain();

        repeat (60) @(posedge clk);
        if (mix_sb.errors == 0 && mix_sb.pending_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
